// File: design/assert_macros.svh
// Assertion macros for the checker file of the code cache table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define JCCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("code cache table assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define JCCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("code cache table assertion failed");

`endif

// File: design/jcct_pkg.sv
// Types, codes and helper functions of the code cache table.
package jcct_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned OFF_W   = 27;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned PROBE_W = 7;
  localparam int unsigned SIZE_W  = 21;
  localparam int unsigned ALIGN_W = 13;
  localparam int unsigned PTR_W   = OFF_W + 1;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_HOT    = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_KEY_ZERO = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_PROBE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_HOT_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROBES    = 1'd1;

  localparam logic [CNT_W-1:0]   HOT_THR_RST    = 17'd100000;
  localparam logic [PROBE_W-1:0] MAX_PROBES_RST = 7'd32;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [OFF_W-1:0] off;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  // Rounds the fill pointer up to a power-of-two alignment; an alignment of zero leaves it as it is.
  function automatic logic [PTR_W-1:0] align_ptr(input logic [OFF_W-1:0] fill,
                                                 input logic [ALIGN_W-1:0] align);
    logic [ALIGN_W-1:0] am1;
    logic [PTR_W-1:0]   sum;
    am1 = align - ALIGN_W'(1);
    sum = {1'b0, fill} + PTR_W'(am1);
    if (align == '0) begin
      return {1'b0, fill};
    end
    return sum & ~PTR_W'(am1);
  endfunction

endpackage

// File: design/jcct_home.sv
// Home slot unit: the key modulo the table depth, by mask or by folding the key sixteen bits at a time.
module jcct_home import jcct_pkg::*; #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [KEY_W-1:0]           pc_i,
  output logic                       done_o,
  output logic [$clog2(ENTRIES)-1:0] home_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam bit          POW2  = (ENTRIES & (ENTRIES - 1)) == 0;

  generate
    if (POW2) begin : g_mask
      logic             done_q;
      logic [IDX_W-1:0] home_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          done_q <= 1'b0;
        end else begin
          done_q <= start_i;
        end
      end

      always_ff @(posedge clk_i) begin
        if (start_i) begin
          home_q <= pc_i[IDX_W-1:0];
        end
      end

      assign done_o = done_q;
      assign home_o = home_q;
    end else begin : g_fold
      // Each 16-bit chunk is handled as a reciprocal estimate of the quotient,
      // then the remainder with a single correction step.
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(ENTRIES));
      localparam logic [32:0] MOD   = 33'(ENTRIES);

      logic             run_q;
      logic             done_q;
      logic [2:0]       cnt_q;
      logic [KEY_W-1:0] sh_q;
      logic [IDX_W-1:0] rem_q;
      logic [31:0]      x_q;
      logic [31:0]      q_q;
      logic [31:0]      x_d;
      logic [63:0]      prod;
      logic [32:0]      qn;
      logic [32:0]      diff;
      logic [32:0]      rem_d;

      assign x_d   = {16'(rem_q), sh_q[KEY_W-1 -: 16]};
      assign prod  = 64'(x_d) * 64'(RECIP);
      assign qn    = 33'(q_q) * MOD;
      assign diff  = {1'b0, x_q} - qn;
      assign rem_d = (diff >= MOD) ? diff - MOD : diff;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          run_q  <= 1'b0;
          done_q <= 1'b0;
          cnt_q  <= '0;
        end else if (start_i) begin
          run_q  <= 1'b1;
          done_q <= 1'b0;
          cnt_q  <= '0;
        end else if (run_q) begin
          cnt_q  <= cnt_q + 3'd1;
          run_q  <= (cnt_q != 3'd7);
          done_q <= (cnt_q == 3'd7);
        end else begin
          done_q <= 1'b0;
        end
      end

      always_ff @(posedge clk_i) begin
        if (start_i) begin
          sh_q  <= pc_i;
          rem_q <= '0;
        end else if (run_q) begin
          if (!cnt_q[0]) begin
            x_q <= x_d;
            q_q <= prod[63:32];
          end else begin
            rem_q <= rem_d[IDX_W-1:0];
            sh_q  <= sh_q << 16;
          end
        end
      end

      assign done_o = done_q;
      assign home_o = rem_q;
    end
  endgenerate

endmodule

// File: design/jcct_table.sv
// Slot memory of the code cache table: one write port and one registered read port.
module jcct_table import jcct_pkg::*; #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  entry_t                     wdata_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  output entry_t                     rdata_o
);

  entry_t mem [ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/jit_code_cache_table_unit.sv
// Top level of the code cache table: sequencer, registers and result port.
//
// A transaction is accepted at a rising edge with start high and busy low; func_i,
// pc_i, code_size_i and code_align_i are sampled there. Exactly one result follows,
// shown on found_o, code_offset_o, is_hot_o and status_o for the single cycle in
// which done_o is high. The receiver cannot stall, so results are never held back.
// A transaction with func 3 or key zero returns in the next cycle. Any other one finds
// the home slot, by mask when ENTRIES is a power of two or else by folding the key
// sixteen bits at a time, then examines slot after slot through the single read port
// of the slot memory, at most max_probes probe steps past the home slot. busy stays
// high while such a transaction runs and is low when done_o is high. Configuration
// writes on cfg_we_i take effect at once; the user is to make them while busy is low,
// which the block itself does not enforce. After reset the slot memory is cleared one
// slot a cycle, every slot, with busy high; configuration writes are taken meanwhile.
module jit_code_cache_table_unit import jcct_pkg::*; #(
  parameter int unsigned ENTRIES     = 1024,
  parameter int unsigned STORE_BYTES = 67108864
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           func_i,
  input  logic [KEY_W-1:0]     pc_i,
  input  logic [SIZE_W-1:0]    code_size_i,
  input  logic [ALIGN_W-1:0]   code_align_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 done_o,
  output logic                 found_o,
  output logic [OFF_W-1:0]     code_offset_o,
  output logic                 is_hot_o,
  output logic [1:0]           status_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [31:0] STORE_LIM = 32'(STORE_BYTES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [PROBE_W-1:0] step_q, step_d;
  logic [OFF_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]   thr_q;
  logic [PROBE_W-1:0] maxp_q;

  logic [1:0]         func_q;
  logic [KEY_W-1:0]   pc_q;
  logic [SIZE_W-1:0]  size_q;
  logic [PTR_W-1:0]   ptr_q;

  logic               done_q, done_d;
  logic               found_q, found_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic               hot_q, hot_d;
  logic [1:0]         status_q, status_d;

  logic               accept;
  logic               home_start;
  logic               home_done;
  logic [IDX_W-1:0]   home;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;
  entry_t             rdata;

  logic               hit;
  logic               empty;
  logic               full;
  logic [31:0]        end_ptr;
  logic [CNT_W:0]     cnt_inc;
  logic [CNT_W-1:0]   cnt_sat;
  logic [IDX_W-1:0]   idx_next;

  assign accept     = start && (state_q == S_IDLE);
  assign home_start = accept && (func_i != FUNC_NOP) && (pc_i != '0);
  assign busy       = (state_q != S_IDLE);

  jcct_home #(
    .ENTRIES(ENTRIES)
  ) u_home (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(home_start),
    .pc_i   (pc_i),
    .done_o (home_done),
    .home_o (home)
  );

  jcct_table #(
    .ENTRIES(ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  assign hit      = (rdata.key == pc_q);
  assign empty    = (rdata.key == '0);
  assign end_ptr  = 32'(ptr_q) + 32'(size_q);
  assign full     = (end_ptr > STORE_LIM);
  assign cnt_inc  = {1'b0, rdata.cnt} + (CNT_W+1)'(1);
  assign cnt_sat  = (cnt_inc > {1'b0, thr_q}) ? thr_q : cnt_inc[CNT_W-1:0];
  assign idx_next = (idx_q == IDX_W'(ENTRIES - 1)) ? '0 : idx_q + IDX_W'(1);

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    idx_d    = idx_q;
    step_d   = step_q;
    fill_d   = fill_q;
    done_d   = 1'b0;
    found_d  = found_q;
    off_d    = off_q;
    hot_d    = hot_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = rdata;

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_NOP || pc_i == '0) begin
            done_d   = 1'b1;
            found_d  = 1'b0;
            off_d    = '0;
            hot_d    = 1'b0;
            status_d = (func_i == FUNC_NOP) ? ST_OK : ST_KEY_ZERO;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (home_done) begin
          idx_d   = home;
          step_d  = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        found_d  = 1'b0;
        off_d    = '0;
        hot_d    = 1'b0;
        status_d = ST_OK;
        if (func_q == FUNC_ADD && full) begin
          done_d   = 1'b1;
          status_d = ST_FULL;
          state_d  = S_IDLE;
        end else if (hit || empty) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          case (func_q)
            FUNC_LOOKUP: begin
              if (hit && rdata.cnt >= thr_q) begin
                found_d = 1'b1;
                off_d   = rdata.off;
              end
            end
            FUNC_ADD: begin
              we        = 1'b1;
              wdata.key = pc_q;
              wdata.off = ptr_q[OFF_W-1:0];
              wdata.cnt = hit ? rdata.cnt : '0;
              fill_d    = end_ptr[OFF_W-1:0];
              found_d   = 1'b1;
              off_d     = ptr_q[OFF_W-1:0];
            end
            FUNC_HOT: begin
              we        = 1'b1;
              wdata.key = pc_q;
              if (hit) begin
                wdata.cnt = cnt_sat;
                hot_d     = (cnt_sat >= thr_q);
              end else begin
                wdata.cnt = CNT_W'(1);
              end
            end
            default: begin
              found_d = 1'b0;
            end
          endcase
        end else if (step_q == maxp_q) begin
          done_d   = 1'b1;
          status_d = ST_PROBE;
          state_d  = S_IDLE;
        end else begin
          step_d  = step_q + PROBE_W'(1);
          idx_d   = idx_next;
          state_d = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      idx_q   <= '0;
      step_q  <= '0;
      fill_q  <= '0;
      done_q  <= 1'b0;
      thr_q   <= HOT_THR_RST;
      maxp_q  <= MAX_PROBES_RST;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HOT_THRESHOLD: thr_q  <= cfg_data_i[CNT_W-1:0];
          CFG_MAX_PROBES:    maxp_q <= cfg_data_i[PROBE_W-1:0];
          default:           thr_q  <= thr_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      pc_q   <= pc_i;
      size_q <= code_size_i;
      ptr_q  <= align_ptr(fill_q, code_align_i);
    end
    found_q  <= found_d;
    off_q    <= off_d;
    hot_q    <= hot_d;
    status_q <= status_d;
  end

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign code_offset_o = off_q;
  assign is_hot_o      = hot_q;
  assign status_o      = status_q;

endmodule

// File: design/jcct_checker.sv
// Port-level checker of the code cache table and its binding to the top level.
`include "assert_macros.svh"

module jcct_checker import jcct_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic             found_o,
  input logic [OFF_W-1:0] code_offset_o,
  input logic             is_hot_o,
  input logic [1:0]       status_o
);

  `JCCT_ASSERT_NEXT(a_accept_then_work, start && !busy, busy || done_o)
  `JCCT_ASSERT_NOW(a_result_when_idle, done_o, !busy)
  `JCCT_ASSERT_NOW(a_fail_clears_fields, done_o && status_o != ST_OK, !found_o && !is_hot_o && code_offset_o == '0)
  `JCCT_ASSERT_NOW(a_found_not_hot, done_o && found_o, status_o == ST_OK && !is_hot_o)

endmodule

bind jit_code_cache_table_unit jcct_checker u_jcct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .found_o      (found_o),
  .code_offset_o(code_offset_o),
  .is_hot_o     (is_hot_o),
  .status_o     (status_o)
);
